>>> sv/pscl_pkg.sv
package pscl_pkg;

    localparam int CNT_W   = 16;
    localparam int ADDR_W  = 32;
    localparam int ID_W    = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int STS_W   = 3;
    // bits folded into the bucket remainder per cycle
    localparam int DIGIT_W = 8;

    localparam logic CMD_OPEN  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLIENTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_IP  = 1'b1;

    typedef enum logic [STS_W-1:0] {
        STS_ADMITTED   = 3'd0,
        STS_TOO_MANY   = 3'd1,
        STS_IP_LIMIT   = 3'd2,
        STS_TABLE_FULL = 3'd3,
        STS_CLOSED     = 3'd4,
        STS_UNKNOWN_ID = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_OPEN,
        ST_CFIND,
        ST_CADDR
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - CNT_W'(1);
    endfunction

endpackage

>>> sv/pscl_bucket.sv
module pscl_bucket import pscl_pkg::*; #(
    parameter int BUCKETS = 64,
    parameter int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ADDR_W-1:0] ip,
    input  logic [ID_W-1:0]   id,
    output logic              done,
    output logic [BKT_W-1:0]  ip_bkt,
    output logic [BKT_W-1:0]  id_bkt
);

    localparam int STEPS  = ADDR_W / DIGIT_W;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [BKT_W:0] B_C = (BKT_W + 1)'(BUCKETS);

    logic [ADDR_W-1:0] ip_sh_reg, id_sh_reg;
    logic [BKT_W-1:0]  ip_rem_reg, id_rem_reg;
    logic [BKT_W-1:0]  ip_rem_next, id_rem_next;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg, done_reg;

    // one bit of long division: remainder stays below the bucket count
    function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] r,
                                                  input logic b);
        logic [BKT_W:0] t;
        t = {r, b};
        if (t >= B_C) begin
            t = t - B_C;
        end
        return t[BKT_W-1:0];
    endfunction

    always_comb begin
        ip_rem_next = ip_rem_reg;
        id_rem_next = id_rem_reg;
        for (int i = 0; i < DIGIT_W; i++) begin
            ip_rem_next = mod_step(ip_rem_next, ip_sh_reg[ADDR_W-1-i]);
            id_rem_next = mod_step(id_rem_next, id_sh_reg[ADDR_W-1-i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ip_sh_reg  <= ip;
            id_sh_reg  <= {{(ADDR_W - ID_W){1'b0}}, id};
            ip_rem_reg <= '0;
            id_rem_reg <= '0;
        end else if (run_reg) begin
            ip_sh_reg  <= {ip_sh_reg[ADDR_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            id_sh_reg  <= {id_sh_reg[ADDR_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            ip_rem_reg <= ip_rem_next;
            id_rem_reg <= id_rem_next;
        end
    end

    assign done   = done_reg;
    assign ip_bkt = ip_rem_reg;
    assign id_bkt = id_rem_reg;

endmodule

>>> sv/per_source_connection_limiter.sv
// Connection admission table with a per-source-address limit.
// Slave channel: one request per connection event; s_tuser is the event kind
// (open or close), s_tdata carries the source address and the connection id.
// Master channel: one result per request with the status in m_tuser and the
// total and per-address counts in m_tdata.
// Limits are written through cfg_wr_en/cfg_addr/cfg_wdata; the user must write them
// only while no request is in flight, as the block does not enforce it; a limit of zero turns that check off.
// Both tables are set-associative row memories (one row per bucket) with
// registered reads; each request reads its rows and writes back the ones it changes.
// From acceptance to result, the bucket index is first computed as a remainder,
// 8 key bits per cycle, then a row read follows; a close needs a second read
// of the address row.
// One request is worked on at a time; a new one is accepted as soon as the
// previous result sits in the output register.
// After reset a clearing pass empties both tables row by row,
// with s_tready low; configuration writes are taken during that time.
// When the receiver stalls, a result waits in the output register and the
// following request waits in its final stage until that register frees up.
module per_source_connection_limiter import pscl_pkg::*; #(
    parameter int BUCKETS = 64,
    parameter int WAYS    = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // ip_address[31:0], conn_id[47:32]
    input  logic                 s_tuser,   // cmd
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // total_count[15:0], ip_count[31:16]
    output logic [STS_W-1:0]     m_tuser    // status
);

    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] key;
    } aent_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   key;
        logic [ADDR_W-1:0] addr;
        logic [BKT_W-1:0]  abkt;
    } cent_t;

    typedef aent_t [WAYS-1:0] arow_t;
    typedef cent_t [WAYS-1:0] crow_t;

    arow_t amem [BUCKETS];
    crow_t cmem [BUCKETS];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  max_clients_reg, max_per_ip_reg;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              cmd_reg;
    logic [ADDR_W-1:0] ip_reg;
    logic [ID_W-1:0]   id_reg;
    logic [BKT_W-1:0]  clr_reg;
    logic [ADDR_W-1:0] cl_addr_reg;
    logic [BKT_W-1:0]  cl_bkt_reg;
    arow_t             arow_reg;
    crow_t             crow_reg;

    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [CNT_W-1:0]  m_total_reg, m_ipc_reg;

    logic              start, bkt_done;
    logic [BKT_W-1:0]  ip_bkt, id_bkt;

    logic              a_we, a_re, c_we, c_re;
    logic [BKT_W-1:0]  a_waddr, a_raddr, c_waddr, c_raddr;
    arow_t             a_wdata;
    crow_t             c_wdata;

    logic              out_free, out_load;
    status_t           out_status;
    logic [CNT_W-1:0]  out_ipc;

    logic [WAYS-1:0]   a_hit_v, a_free_v, c_hit_v, c_free_v, cl_hit_v;
    logic [WAY_W:0]    a_hit, a_free, c_hit, c_free, cl_hit;
    logic [WAY_W-1:0]  a_way, c_way;
    logic              c_ok, full;
    logic [CNT_W-1:0]  old_cnt, open_cnt, total_inc, close_cnt;
    status_t           open_status;

    // lowest set way: {found, index}
    function automatic logic [WAY_W:0] pick(input logic [WAYS-1:0] v);
        logic [WAY_W:0] r;
        r = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (v[w]) begin
                r = {1'b1, WAY_W'(w)};
            end
        end
        return r;
    endfunction

    pscl_bucket #(
        .BUCKETS(BUCKETS),
        .BKT_W  (BKT_W)
    ) u_bucket (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (start),
        .ip     (s_tdata[31:0]),
        .id     (s_tdata[47:32]),
        .done   (bkt_done),
        .ip_bkt (ip_bkt),
        .id_bkt (id_bkt)
    );

    // way matching on the rows just read
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            a_hit_v[w]  = (arow_reg[w].count != '0) && (arow_reg[w].key == ip_reg);
            a_free_v[w] = (arow_reg[w].count == '0);
            c_hit_v[w]  = crow_reg[w].valid && (crow_reg[w].key == id_reg);
            c_free_v[w] = !crow_reg[w].valid;
            cl_hit_v[w] = (arow_reg[w].count != '0) && (arow_reg[w].key == cl_addr_reg);
        end
        a_hit  = pick(a_hit_v);
        a_free = pick(a_free_v);
        c_hit  = pick(c_hit_v);
        c_free = pick(c_free_v);
        cl_hit = pick(cl_hit_v);

        a_way = a_hit[WAY_W] ? a_hit[WAY_W-1:0] : a_free[WAY_W-1:0];
        c_way = c_hit[WAY_W] ? c_hit[WAY_W-1:0] : c_free[WAY_W-1:0];
        c_ok  = c_hit[WAY_W] || c_free[WAY_W];
        full  = !c_ok || !(a_hit[WAY_W] || a_free[WAY_W]);

        old_cnt   = a_hit[WAY_W] ? arow_reg[a_hit[WAY_W-1:0]].count : '0;
        open_cnt  = sat_inc(old_cnt);
        total_inc = sat_inc(total_reg);
        close_cnt = sat_dec(arow_reg[cl_hit[WAY_W-1:0]].count);

        if (full) begin
            open_status = STS_TABLE_FULL;
        end else if (max_clients_reg != '0 && total_inc > max_clients_reg) begin
            open_status = STS_TOO_MANY;
        end else if (max_per_ip_reg != '0 && open_cnt > max_per_ip_reg) begin
            open_status = STS_IP_LIMIT;
        end else begin
            open_status = STS_ADMITTED;
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign start    = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        total_next = total_reg;
        a_we       = 1'b0;
        a_re       = 1'b0;
        c_we       = 1'b0;
        c_re       = 1'b0;
        a_waddr    = ip_bkt;
        a_raddr    = ip_bkt;
        c_waddr    = id_bkt;
        c_raddr    = id_bkt;
        a_wdata    = arow_reg;
        c_wdata    = crow_reg;
        out_load   = 1'b0;
        out_status = STS_CLOSED;
        out_ipc    = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                a_we    = 1'b1;
                c_we    = 1'b1;
                a_waddr = clr_reg;
                c_waddr = clr_reg;
                a_wdata = '0;
                c_wdata = '0;
                if (clr_reg == BKT_W'(BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (bkt_done) begin
                    a_re       = 1'b1;
                    c_re       = 1'b1;
                    state_next = (cmd_reg == CMD_OPEN) ? ST_OPEN : ST_CFIND;
                end
            end
            ST_OPEN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = open_status;
                    total_next = total_inc;
                    out_ipc    = full ? old_cnt : open_cnt;
                    if (!full) begin
                        a_we                 = 1'b1;
                        c_we                 = 1'b1;
                        a_wdata[a_way].count = open_cnt;
                        a_wdata[a_way].key   = ip_reg;
                        c_wdata[c_way].valid = 1'b1;
                        c_wdata[c_way].key   = id_reg;
                        c_wdata[c_way].addr  = ip_reg;
                        c_wdata[c_way].abkt  = ip_bkt;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_CFIND: begin
                if (c_hit[WAY_W]) begin
                    // free the id entry and fetch the owning address row
                    c_we                              = 1'b1;
                    c_wdata[c_hit[WAY_W-1:0]].valid   = 1'b0;
                    a_re                              = 1'b1;
                    a_raddr                           = crow_reg[c_hit[WAY_W-1:0]].abkt;
                    state_next                        = ST_CADDR;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_status = STS_UNKNOWN_ID;
                    total_next = sat_dec(total_reg);
                    state_next = ST_IDLE;
                end
            end
            ST_CADDR: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = STS_CLOSED;
                    total_next = sat_dec(total_reg);
                    if (cl_hit[WAY_W]) begin
                        a_we                          = 1'b1;
                        a_waddr                       = cl_bkt_reg;
                        a_wdata[cl_hit[WAY_W-1:0]].count = close_cnt;
                        out_ipc                       = close_cnt;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg         <= '0;
            total_reg       <= '0;
            max_clients_reg <= '0;
            max_per_ip_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + BKT_W'(1);
            end
            total_reg <= total_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_MAX_CLIENTS: max_clients_reg <= cfg_wdata;
                    CFG_MAX_PER_IP:  max_per_ip_reg  <= cfg_wdata;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cmd_reg <= s_tuser;
            ip_reg  <= s_tdata[31:0];
            id_reg  <= s_tdata[47:32];
        end
        if (state_reg == ST_CFIND) begin
            cl_addr_reg <= crow_reg[c_hit[WAY_W-1:0]].addr;
            cl_bkt_reg  <= crow_reg[c_hit[WAY_W-1:0]].abkt;
        end
        if (out_load) begin
            m_status_reg <= out_status;
            m_total_reg  <= total_next;
            m_ipc_reg    <= out_ipc;
        end
    end

    // table memories
    always_ff @(posedge aclk) begin
        if (a_we) begin
            amem[a_waddr] <= a_wdata;
        end
        if (a_re) begin
            arow_reg <= amem[a_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (c_we) begin
            cmem[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            crow_reg <= cmem[c_raddr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_ipc_reg, m_total_reg};

    a_bkt_in_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        bkt_done |-> state_reg == ST_HASH)
        else $error("bucket index finished outside the hash stage");

    a_counted_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STS_ADMITTED || m_tuser == STS_TOO_MANY ||
                     m_tuser == STS_IP_LIMIT) |-> m_tdata[31:16] != '0)
        else $error("recorded open reports a zero address count");

    a_admit_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STS_ADMITTED && max_clients_reg != '0
        |-> m_tdata[15:0] <= max_clients_reg)
        else $error("admitted beyond the total limit");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OPEN ||
                            $past(state_reg) == ST_CFIND ||
                            $past(state_reg) == ST_CADDR)
        else $error("result raised outside a final stage");

endmodule

>>> verif/tb_per_source_connection_limiter.sv
module tb_per_source_connection_limiter;
    import pscl_pkg::*;

    localparam int BUCKETS = 64;
    localparam int WAYS    = 4;
    localparam int SLOTS   = BUCKETS * WAYS;

    localparam int          SETTLE_CYCLES  = 16;
    localparam int unsigned LIMIT_CYCLES   = 4_000_000;
    localparam int          RAND_PHASES    = 6;
    localparam int          RAND_PER_PHASE = 300;
    localparam int          POOL_LEN       = 10;
    localparam int          SAT_OPENS      = 65540;
    localparam logic [15:0] SAT_ID         = 16'h1234;
    localparam int          MAX_PRINTED    = 100;

    typedef struct packed {
        status_t     status;
        logic [15:0] total;
        logic [15:0] ip_count;
    } verdict_t;

    typedef enum logic [1:0] {
        ROW_LIMITS,
        ROW_PREDICTED,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        cmd;
        logic [31:0] ip;
        logic [15:0] id;
        logic [15:0] clients;
        logic [15:0] per_ip;
        verdict_t    want;
    } script_row_t;

    localparam int SCRIPT_LEN = 26;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // close on an empty table, total holds at zero
        '{ROW_TYPED, CMD_CLOSE, 32'h0000_0000, 16'h0000, 16'd0, 16'd0,
          '{STS_UNKNOWN_ID, 16'd0, 16'd0}},
        '{ROW_TYPED, CMD_OPEN, 32'h0000_0000, 16'h0000, 16'd0, 16'd0,
          '{STS_ADMITTED, 16'd1, 16'd1}},
        '{ROW_TYPED, CMD_OPEN, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0,
          '{STS_ADMITTED, 16'd2, 16'd1}},
        '{ROW_TYPED, CMD_OPEN, 32'h0000_0000, 16'h0040, 16'd0, 16'd0,
          '{STS_ADMITTED, 16'd3, 16'd2}},
        // id 0 reopened from another address, old address keeps its count
        '{ROW_TYPED, CMD_OPEN, 32'hC0A8_0140, 16'h0000, 16'd0, 16'd0,
          '{STS_ADMITTED, 16'd4, 16'd1}},
        '{ROW_TYPED, CMD_CLOSE, 32'hFFFF_FFFF, 16'h0000, 16'd0, 16'd0,
          '{STS_CLOSED, 16'd3, 16'd0}},
        '{ROW_TYPED, CMD_CLOSE, 32'h0000_0000, 16'h0040, 16'd0, 16'd0,
          '{STS_CLOSED, 16'd2, 16'd1}},
        // fill address bucket 1, then one more address
        '{ROW_PREDICTED, CMD_OPEN, 32'h0000_0001, 16'h0002, 16'd0, 16'd0, '0},
        '{ROW_PREDICTED, CMD_OPEN, 32'h0000_0041, 16'h0003, 16'd0, 16'd0, '0},
        '{ROW_PREDICTED, CMD_OPEN, 32'h0000_0081, 16'h0004, 16'd0, 16'd0, '0},
        '{ROW_PREDICTED, CMD_OPEN, 32'h0000_00C1, 16'h0005, 16'd0, 16'd0, '0},
        '{ROW_TYPED, CMD_OPEN, 32'h0000_0101, 16'h0006, 16'd0, 16'd0,
          '{STS_TABLE_FULL, 16'd7, 16'd0}},
        '{ROW_PREDICTED, CMD_OPEN, 32'h0000_0041, 16'h0007, 16'd0, 16'd0, '0},
        // fill id bucket 9, then one more id
        '{ROW_PREDICTED, CMD_OPEN, 32'h0A0B_0C0D, 16'h0009, 16'd0, 16'd0, '0},
        '{ROW_PREDICTED, CMD_OPEN, 32'h0A0B_0C0D, 16'h0049, 16'd0, 16'd0, '0},
        '{ROW_PREDICTED, CMD_OPEN, 32'h0A0B_0C0D, 16'h0089, 16'd0, 16'd0, '0},
        '{ROW_PREDICTED, CMD_OPEN, 32'h0A0B_0C0D, 16'h00C9, 16'd0, 16'd0, '0},
        '{ROW_TYPED, CMD_OPEN, 32'h0A0B_0C0D, 16'h0109, 16'd0, 16'd0,
          '{STS_TABLE_FULL, 16'd13, 16'd4}},
        '{ROW_TYPED, CMD_CLOSE, 32'h0000_0000, 16'h0109, 16'd0, 16'd0,
          '{STS_UNKNOWN_ID, 16'd12, 16'd0}},
        '{ROW_LIMITS, CMD_OPEN, 32'h0, 16'h0, 16'd12, 16'd5, '0},
        '{ROW_TYPED, CMD_OPEN, 32'h0A0B_0C0D, 16'h0020, 16'd0, 16'd0,
          '{STS_TOO_MANY, 16'd13, 16'd5}},
        // both limits exceeded, total limit wins
        '{ROW_TYPED, CMD_OPEN, 32'h0A0B_0C0D, 16'h0021, 16'd0, 16'd0,
          '{STS_TOO_MANY, 16'd14, 16'd6}},
        '{ROW_LIMITS, CMD_OPEN, 32'h0, 16'h0, 16'd0, 16'd5, '0},
        '{ROW_TYPED, CMD_OPEN, 32'h0A0B_0C0D, 16'h0022, 16'd0, 16'd0,
          '{STS_IP_LIMIT, 16'd15, 16'd7}},
        '{ROW_TYPED, CMD_CLOSE, 32'h0000_0000, 16'h0022, 16'd0, 16'd0,
          '{STS_CLOSED, 16'd14, 16'd6}},
        '{ROW_PREDICTED, CMD_CLOSE, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0, '0}
    };

    localparam logic [15:0] PHASE_CLIENTS [RAND_PHASES] =
        '{16'hFFFF, 16'd20, 16'd0, 16'd1, 16'd40, 16'd8};
    localparam logic [15:0] PHASE_PER_IP [RAND_PHASES] =
        '{16'hFFFF, 16'd3, 16'd2, 16'd1, 16'd0, 16'hFFFF};

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [47:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic [STS_W-1:0]     m_tuser;

    // admission state as the block should hold it
    logic [31:0] ip_key  [SLOTS] = '{default: '0};
    logic [15:0] ip_cnt  [SLOTS] = '{default: '0};
    logic [15:0] id_key  [SLOTS] = '{default: '0};
    logic [31:0] id_ip   [SLOTS] = '{default: '0};
    bit          id_used [SLOTS] = '{default: 1'b0};
    logic [15:0] open_total  = '0;
    logic [15:0] lim_clients = '0;
    logic [15:0] lim_per_ip  = '0;

    verdict_t    awaited_verdicts [$];
    logic [31:0] addr_pool [POOL_LEN];
    bit          no_idle = 1'b0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    per_source_connection_limiter #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int bucket_base(input logic [31:0] key);
        return int'(key % BUCKETS) * WAYS;
    endfunction

    function automatic int lookup_ip(input logic [31:0] ip);
        int b;
        b = bucket_base(ip);
        for (int w = 0; w < WAYS; w++)
            if (ip_cnt[b + w] != 0 && ip_key[b + w] == ip) return b + w;
        return -1;
    endfunction

    function automatic int free_ip_slot(input logic [31:0] ip);
        int b;
        b = bucket_base(ip);
        for (int w = 0; w < WAYS; w++)
            if (ip_cnt[b + w] == 0) return b + w;
        return -1;
    endfunction

    function automatic int lookup_id(input logic [15:0] id);
        int b;
        b = bucket_base(32'(id));
        for (int w = 0; w < WAYS; w++)
            if (id_used[b + w] && id_key[b + w] == id) return b + w;
        return -1;
    endfunction

    function automatic int free_id_slot(input logic [15:0] id);
        int b;
        b = bucket_base(32'(id));
        for (int w = 0; w < WAYS; w++)
            if (!id_used[b + w]) return b + w;
        return -1;
    endfunction

    function automatic verdict_t admit_event(input logic cmd, input logic [31:0] ip,
                                             input logic [15:0] id);
        verdict_t v;
        int a;
        int c;
        int f;
        v.ip_count = '0;
        if (cmd == CMD_OPEN) begin
            open_total = (open_total == 16'hFFFF) ? open_total : open_total + 16'd1;
            a = lookup_ip(ip);
            c = lookup_id(id);
            if (c < 0) c = free_id_slot(id);
            if (a < 0) begin
                f = free_ip_slot(ip);
                // a new address entry is only claimed when the id has a slot too
                if (f >= 0 && c >= 0) begin
                    ip_key[f] = ip;
                    ip_cnt[f] = '0;
                end
                a = (c >= 0) ? f : -1;
            end
            if (a < 0 || c < 0) begin
                f = lookup_ip(ip);
                v.status = STS_TABLE_FULL;
                if (f >= 0) v.ip_count = ip_cnt[f];
            end else begin
                ip_cnt[a] = (ip_cnt[a] == 16'hFFFF) ? ip_cnt[a] : ip_cnt[a] + 16'd1;
                v.ip_count = ip_cnt[a];
                id_key[c]  = id;
                id_ip[c]   = ip;
                id_used[c] = 1'b1;
                if (lim_clients != 0 && open_total > lim_clients)
                    v.status = STS_TOO_MANY;
                else if (lim_per_ip != 0 && v.ip_count > lim_per_ip)
                    v.status = STS_IP_LIMIT;
                else
                    v.status = STS_ADMITTED;
            end
        end else begin
            open_total = (open_total == 16'd0) ? open_total : open_total - 16'd1;
            c = lookup_id(id);
            if (c < 0) begin
                v.status = STS_UNKNOWN_ID;
            end else begin
                a = lookup_ip(id_ip[c]);
                if (a >= 0) begin
                    ip_cnt[a] = (ip_cnt[a] == 16'd0) ? ip_cnt[a] : ip_cnt[a] - 16'd1;
                    v.ip_count = ip_cnt[a];
                end
                id_used[c] = 1'b0;
                v.status = STS_CLOSED;
            end
        end
        v.total = open_total;
        return v;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ids crowded into a few buckets so the id table fills up
    function automatic logic [15:0] pick_conn_id();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 7) * BUCKETS + $urandom_range(0, 11));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatches < MAX_PRINTED)
            $display("mismatch in %s: expected %0h, got %0h (cycle %0d)",
                     what, want, got, cycle_count);
        mismatches++;
    endtask

    task automatic send_event(input logic cmd, input logic [31:0] ip, input logic [15:0] id,
                              input bit typed_row, input verdict_t typed);
        verdict_t v;
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {id, ip};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        v = admit_event(cmd, ip, id);
        awaited_verdicts.push_back(typed_row ? typed : v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [15:0] clients, input logic [15:0] per_ip);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_MAX_CLIENTS;
        cfg_wdata <= clients;
        @(posedge aclk);
        cfg_addr  <= CFG_MAX_PER_IP;
        cfg_wdata <= per_ip;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        lim_clients = clients;
        lim_per_ip  = per_ip;
    endtask

    task automatic random_event();
        logic [31:0] ip;
        logic [15:0] id;
        logic [15:0] live_ids [$];
        int roll;
        roll = $urandom_range(0, 99);
        ip = $urandom;
        if (roll < 55) begin
            if ($urandom_range(0, 3) != 0) ip = addr_pool[$urandom_range(0, POOL_LEN - 1)];
            send_event(CMD_OPEN, ip, pick_conn_id(), 1'b0, '0);
        end else begin
            for (int s = 0; s < SLOTS; s++)
                if (id_used[s]) live_ids.push_back(id_key[s]);
            if (live_ids.size() != 0 && $urandom_range(0, 9) < 7)
                id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            else
                id = pick_conn_id();
            send_event(CMD_CLOSE, ip, id, 1'b0, '0);
        end
    endtask

    // result side stalls
    initial begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 20) hold = idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_verdicts.size() == 0) begin
                report_mismatch("result with no request pending", '0, {m_tdata[15:0], 13'd0,
                                m_tuser});
            end else begin
                want = awaited_verdicts.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[15:0] !== want.total)
                    report_mismatch("total_count", 32'(want.total), 32'(m_tdata[15:0]));
                if (m_tdata[31:16] !== want.ip_count)
                    report_mismatch("ip_count", 32'(want.ip_count), 32'(m_tdata[31:16]));
            end
        end
    end

    initial begin
        logic [31:0] sat_ip;
        logic [15:0] live_ids [$];
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_OPEN;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_MAX_CLIENTS;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].kind == ROW_LIMITS) begin
                drain();
                write_limits(SCRIPT[i].clients, SCRIPT[i].per_ip);
            end else begin
                send_event(SCRIPT[i].cmd, SCRIPT[i].ip, SCRIPT[i].id,
                           SCRIPT[i].kind == ROW_TYPED, SCRIPT[i].want);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            write_limits(PHASE_CLIENTS[p], PHASE_PER_IP[p]);
            no_idle = (p == 2);
            // some addresses share the low buckets so address sets fill up
            for (int k = 0; k < POOL_LEN; k++)
                addr_pool[k] = (k < 6) ? {26'($urandom), 6'($urandom_range(0, 2))}
                                       : 32'($urandom);
            repeat (RAND_PER_PHASE) random_event();
        end

        // count saturation: empty the id table, then reopen one id from one address
        no_idle = 1'b1;
        drain();
        for (int s = 0; s < SLOTS; s++)
            if (id_used[s]) live_ids.push_back(id_key[s]);
        foreach (live_ids[j]) send_event(CMD_CLOSE, 32'($urandom), live_ids[j], 1'b0, '0);
        drain();
        write_limits(16'hFFFF, 16'hFFFF);
        sat_ip = 32'h5EED_0A01;
        for (int s = SLOTS - 1; s >= 0; s--)
            if (ip_cnt[s] != 0) sat_ip = ip_key[s];
        repeat (SAT_OPENS) send_event(CMD_OPEN, sat_ip, SAT_ID, 1'b0, '0);
        send_event(CMD_CLOSE, sat_ip, SAT_ID, 1'b0, '0);
        drain();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/pscl_pkg.sv
sv/pscl_bucket.sv
sv/per_source_connection_limiter.sv
verif/tb_per_source_connection_limiter.sv
